/* design/iirdf2_pkg.sv */
// Shared types, constants and rounding helpers for the direct form II IIR filter.
package iirdf2_pkg;

  // Field widths of the sample, coefficient, history and accumulator words.
  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 32;
  localparam int HIST_W     = 32;
  localparam int ACC_W      = 64;
  localparam int ORD_W      = 4;
  localparam int SLOT_W     = 3;
  localparam int ACT_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int PROD_SHIFT = 13;
  localparam int RND_SHIFT  = 16;
  localparam int FRAC_SHIFT = 39;

  localparam logic signed [ACC_W-1:0] RND_HALF = 64'sd32768;
  localparam logic signed [ACC_W-1:0] W_MAX    = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] W_MIN    = -64'sd2147483648;
  localparam logic signed [ACC_W-1:0] Y_MAX    = 64'sd8388607;
  localparam logic signed [ACC_W-1:0] Y_MIN    = -64'sd8388608;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FF_ORDER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_ORDER = 1'b1;

  // Kind of input item.
  typedef enum logic [ACT_W-1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_WR_FF  = 2'd1,
    ACT_WR_FB  = 2'd2,
    ACT_NONE   = 2'd3
  } act_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FB,
    ST_FB_WAIT,
    ST_W,
    ST_WR,
    ST_FF,
    ST_FF_WAIT,
    ST_Y
  } state_t;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic load;
    logic issue;
  } mac_ctl_t;

  typedef struct packed {
    logic              clip;
    logic [HIST_W-1:0] val;
  } w_res_t;

  typedef struct packed {
    logic                clip;
    logic [SAMPLE_W-1:0] val;
  } y_res_t;

  // Round a Q.39 sum half up to Q.23 and saturate to the Q9.23 history word.
  function automatic w_res_t sat_w(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] r;
    w_res_t res;
    r = (acc + RND_HALF) >>> RND_SHIFT;
    res.clip = 1'b0;
    res.val  = r[HIST_W-1:0];
    if (r > W_MAX) begin
      res.clip = 1'b1;
      res.val  = W_MAX[HIST_W-1:0];
    end else if (r < W_MIN) begin
      res.clip = 1'b1;
      res.val  = W_MIN[HIST_W-1:0];
    end
    return res;
  endfunction

  // Round a Q.39 sum half up to Q.23 and saturate to the Q1.23 output sample.
  function automatic y_res_t sat_y(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] r;
    y_res_t res;
    r = (acc + RND_HALF) >>> RND_SHIFT;
    res.clip = 1'b0;
    res.val  = r[SAMPLE_W-1:0];
    if (r > Y_MAX) begin
      res.clip = 1'b1;
      res.val  = Y_MAX[SAMPLE_W-1:0];
    end else if (r < Y_MIN) begin
      res.clip = 1'b1;
      res.val  = Y_MIN[SAMPLE_W-1:0];
    end
    return res;
  endfunction

endpackage

/* design/iirdf2_coef_mem.sv */
// Coefficient memory holding the feedforward and feedback tables side by side.
module iirdf2_coef_mem
  import iirdf2_pkg::*;
#(
  parameter int TAPS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic                     wr_sel,
  input  logic [$clog2(TAPS)-1:0]  wr_idx,
  input  logic [COEF_W-1:0]        wr_data,
  input  logic                     rd_sel,
  input  logic [$clog2(TAPS)-1:0]  rd_idx,
  output logic signed [COEF_W-1:0] rd_data
);

  localparam int AW    = $clog2(TAPS);
  localparam int DEPTH = 2 ** (AW + 1);

  logic [COEF_W-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  logic [COEF_W-1:0] rd_data_r;
  logic [AW:0]       wr_addr;
  logic [AW:0]       rd_addr;

  // The select bit picks the feedback half of the memory.
  assign wr_addr = {wr_sel, wr_idx};
  assign rd_addr = {rd_sel, rd_idx};

  // Entries not yet written read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= valid_r[rd_addr] ? mem_r[rd_addr] : '0;
  end

  assign rd_data = rd_data_r;

endmodule

/* design/iirdf2_hist_mem.sv */
// Circular history memory of the auxiliary value w, newest entry at the pointer.
module iirdf2_hist_mem
  import iirdf2_pkg::*;
#(
  parameter int TAPS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [HIST_W-1:0]        push_data,
  input  logic [$clog2(TAPS)-1:0]  rd_off,
  output logic signed [HIST_W-1:0] rd_data
);

  localparam int AW = $clog2(TAPS);

  logic [HIST_W-1:0] mem_r [TAPS];
  logic [TAPS-1:0]   valid_r;
  logic [AW-1:0]     ptr_r;
  logic [AW-1:0]     ptr_nxt;
  logic [AW:0]       rd_sum;
  logic [AW-1:0]     rd_addr;
  logic [HIST_W-1:0] rd_data_r;

  // A push moves the pointer back one slot, overwriting the oldest entry.
  assign ptr_nxt = (ptr_r == '0) ? AW'(TAPS - 1) : ptr_r - 1'b1;

  // Offset k reads w delayed by k+1 before a push, by k after it.
  assign rd_sum  = {1'b0, ptr_r} + {1'b0, rd_off};
  assign rd_addr = (rd_sum >= (AW + 1)'(TAPS)) ? AW'(rd_sum - (AW + 1)'(TAPS))
                                                : rd_sum[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r   <= '0;
      valid_r <= '0;
    end else if (push) begin
      ptr_r            <= ptr_nxt;
      valid_r[ptr_nxt] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[ptr_nxt] <= push_data;
    end
  end

  // Cleared history reads as zero until written.
  always_ff @(posedge clk) begin
    rd_data_r <= valid_r[rd_addr] ? mem_r[rd_addr] : '0;
  end

  assign rd_data = rd_data_r;

endmodule

/* design/iirdf2_mac.sv */
// Shared multiply-accumulate unit: one registered product and a 64-bit sum.
module iirdf2_mac
  import iirdf2_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctl_t                 ctl,
  input  logic signed [ACC_W-1:0]  load_val,
  input  logic signed [COEF_W-1:0] coef,
  input  logic signed [HIST_W-1:0] hist,
  output logic signed [ACC_W-1:0]  acc,
  output logic                     busy
);

  logic                    s1_vld_r;
  logic                    s2_vld_r;
  logic signed [ACC_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;

  // Tap valid follows the memory read latency, then the product register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= ctl.issue;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= coef * hist;
  end

  // Each Q12.52 product is floored to Q.39 before it enters the sum.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc_r <= load_val;
    end else if (s2_vld_r) begin
      acc_r <= acc_r + (prod_r >>> PROD_SHIFT);
    end
  end

  assign acc  = acc_r;
  assign busy = s1_vld_r | s2_vld_r;

endmodule

/* design/iir_filter_direct_form_two.sv */
// Top level of the direct form II IIR filter: sequencer, registers and output stage.
//
// Input items arrive on in_tvalid/in_tready with the action code in in_tuser.
// A sample item runs the feedback taps and then the feedforward taps through
// one shared multiply-accumulate unit, reading coefficients and history from
// two memories with registered reads; it yields one output item with the
// saturation flag in out_tuser. Coefficient write items and the unused action
// code finish in their acceptance cycle and yield nothing.
// After acceptance a sample runs the fb-1 feedback taps, waits for the read
// and multiply stages to empty, rounds w, stores w, runs the ff feedforward
// taps, waits again and rounds the output, fb and ff being the clamped
// orders. With no taps in a pass the sequencer goes straight to its wait.
// Only one sample is in flight; in_tready is high while the sequencer is idle.
// The output register holds a result until it is taken; a new item is accepted
// meanwhile, and a second result waits in the last step until the register
// frees up.
// Reset clears the history and both tables to zero, sets both orders to one
// and empties the output register. The user must write the orders via cfg_wr_en,
// cfg_index and cfg_data while no sample is in flight; the block does not check.
module iir_filter_direct_form_two
  import iirdf2_pkg::*;
#(
  parameter int TAPS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,   // sample_in[23:0], coef_index[26:24], coef_value[58:27]
  input  logic [ACT_W-1:0]     in_tuser,   // action[1:0]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [SAMPLE_W-1:0]  out_tdata,  // sample_out[23:0]
  output logic                 out_tuser,  // saturated[0]
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ORD_W-1:0]     cfg_data
);

  localparam int AW = $clog2(TAPS);
  localparam int CW = $clog2(TAPS + 1);

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           k_r, k_nxt;
  logic [ORD_W-1:0]        ff_ord_r, fb_ord_r;
  logic [HIST_W-1:0]       w_r;
  logic                    clip_r;
  logic                    out_tvalid_r, out_tvalid_nxt;
  logic [SAMPLE_W-1:0]     out_tdata_r;
  logic                    out_tuser_r;

  logic                    in_fire;
  act_t                    act;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic [SLOT_W-1:0]       coef_index;
  logic [COEF_W-1:0]       coef_value;
  logic [CW-1:0]           n_ff, n_fb, fb_c, n_cur;
  logic                    k_last;
  logic                    out_free;
  logic                    out_load;
  w_res_t                  w_res;
  y_res_t                  y_res;

  mac_ctl_t                mac_ctl;
  logic signed [ACC_W-1:0] mac_load_val;
  logic signed [ACC_W-1:0] mac_acc;
  logic                    mac_busy;
  logic                    coef_wr_en;
  logic                    coef_rd_sel;
  logic [AW-1:0]           coef_rd_idx;
  logic signed [COEF_W-1:0] coef_rd_data;
  logic                    hist_push;
  logic signed [HIST_W-1:0] hist_rd_data;

  // Unpack the input item.
  assign in_fire    = in_tvalid & in_tready;
  assign act        = act_t'(in_tuser);
  assign sample_in  = in_tdata[SAMPLE_W-1:0];
  assign coef_index = in_tdata[SAMPLE_W+SLOT_W-1:SAMPLE_W];
  assign coef_value = in_tdata[SAMPLE_W+SLOT_W+COEF_W-1:SAMPLE_W+SLOT_W];

  // Orders above the tap count act as the tap count.
  assign n_ff = (32'(ff_ord_r) > TAPS) ? CW'(TAPS) : CW'(ff_ord_r);
  assign fb_c = (32'(fb_ord_r) > TAPS) ? CW'(TAPS) : CW'(fb_ord_r);
  assign n_fb = (fb_c > CW'(1)) ? fb_c - 1'b1 : '0;

  assign n_cur    = (state_r == ST_FB) ? n_fb : n_ff;
  assign k_last   = (k_r == n_cur - 1'b1);
  assign out_free = !out_tvalid_r || out_tready;
  assign w_res    = sat_w(mac_acc);
  assign y_res    = sat_y(mac_acc);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_ord_r <= ORD_W'(1);
      fb_ord_r <= ORD_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FF_ORDER: ff_ord_r <= cfg_data;
        CFG_FB_ORDER: fb_ord_r <= cfg_data;
        default:      ff_ord_r <= ff_ord_r;
      endcase
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && act == ACT_SAMPLE) begin
          state_nxt = (n_fb == '0) ? ST_FB_WAIT : ST_FB;
        end
      end
      ST_FB: begin
        if (k_last) state_nxt = ST_FB_WAIT;
      end
      ST_FB_WAIT: begin
        if (!mac_busy) state_nxt = ST_W;
      end
      ST_W: begin
        state_nxt = ST_WR;
      end
      ST_WR: begin
        state_nxt = (n_ff == '0) ? ST_FF_WAIT : ST_FF;
      end
      ST_FF: begin
        if (k_last) state_nxt = ST_FF_WAIT;
      end
      ST_FF_WAIT: begin
        if (!mac_busy) state_nxt = ST_Y;
      end
      ST_Y: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_tready    = (state_r == ST_IDLE);
    mac_ctl      = '0;
    mac_load_val = '0;
    coef_wr_en   = 1'b0;
    coef_rd_sel  = (state_r == ST_FB);
    coef_rd_idx  = k_r[AW-1:0];
    hist_push    = 1'b0;
    out_load     = 1'b0;
    k_nxt        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (act)
            ACT_SAMPLE: begin
              mac_ctl.load = 1'b1;
              mac_load_val = {{(ACC_W-SAMPLE_W-FRAC_SHIFT){sample_in[SAMPLE_W-1]}},
                              sample_in, {FRAC_SHIFT{1'b0}}};
            end
            ACT_WR_FF, ACT_WR_FB: begin
              coef_wr_en = (32'(coef_index) < TAPS);
            end
            ACT_NONE: begin
              coef_wr_en = 1'b0;
            end
            default: coef_wr_en = 1'b0;
          endcase
        end
      end
      ST_FB: begin
        // Feedback tap j = k+1 pairs with w delayed by k+1.
        mac_ctl.issue = 1'b1;
        coef_rd_idx   = k_r[AW-1:0] + 1'b1;
        k_nxt         = k_last ? '0 : k_r + 1'b1;
      end
      ST_WR: begin
        hist_push    = 1'b1;
        mac_ctl.load = 1'b1;
      end
      ST_FF: begin
        mac_ctl.issue = 1'b1;
        k_nxt         = k_last ? '0 : k_r + 1'b1;
      end
      ST_Y: begin
        out_load = out_free;
      end
      ST_FB_WAIT, ST_W, ST_FF_WAIT: begin
        k_nxt = '0;
      end
      default: k_nxt = '0;
    endcase
  end

  // Output register: a new result is loaded only when the old one is gone.
  always_comb begin
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      k_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      k_r          <= k_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Rounded w and the result payload.
  always_ff @(posedge clk) begin
    if (state_r == ST_W) begin
      w_r    <= w_res.val;
      clip_r <= w_res.clip;
    end
    if (out_load) begin
      out_tdata_r <= y_res.val;
      out_tuser_r <= clip_r | y_res.clip;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  iirdf2_coef_mem #(
    .TAPS (TAPS)
  ) u_coef_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (coef_wr_en),
    .wr_sel  (act == ACT_WR_FB),
    .wr_idx  (AW'(coef_index)),
    .wr_data (coef_value),
    .rd_sel  (coef_rd_sel),
    .rd_idx  (coef_rd_idx),
    .rd_data (coef_rd_data)
  );

  iirdf2_hist_mem #(
    .TAPS (TAPS)
  ) u_hist_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (hist_push),
    .push_data (w_r),
    .rd_off    (k_r[AW-1:0]),
    .rd_data   (hist_rd_data)
  );

  iirdf2_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mac_ctl),
    .load_val (mac_load_val),
    .coef     (coef_rd_data),
    .hist     (hist_rd_data),
    .acc      (mac_acc),
    .busy     (mac_busy)
  );

  // The history changes only after all feedback products have been summed.
  a_push_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    hist_push |-> !mac_busy)
    else $error("history written while products are still in flight");

  // Reloading the sum must not drop a product still in the pipeline.
  a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    mac_ctl.load |-> !mac_busy)
    else $error("accumulator reloaded while products are still in flight");

  // A result appears only from the output rounding step.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_Y))
    else $error("output item raised outside the rounding step");

endmodule

/* dv/iir_filter_direct_form_two_tb.sv */
// Self-checking testbench for the direct form II IIR filter with stream ports.
`timescale 1ns / 100ps

// Tracks every accepted item, predicts the output of each sample and checks the output stream.
class df2_output_board;
  localparam int NTAPS = 8;
  localparam longint HIST_MAX = 64'sd2147483647;
  localparam longint HIST_MIN = -64'sd2147483648;
  localparam longint OUT_MAX = 64'sd8388607;
  localparam longint OUT_MIN = -64'sd8388608;

  logic [3:0] ff_order;
  logic [3:0] fb_order;
  logic signed [31:0] aux_line [NTAPS];
  logic signed [31:0] ff_coef [NTAPS];
  logic signed [31:0] fb_coef [NTAPS];
  // Each entry holds {saturated, sample_out}.
  logic [24:0] expected_outputs [$];
  int mismatches;

  function new();
    ff_order = 4'd1;
    fb_order = 4'd1;
    foreach (aux_line[i]) begin
      aux_line[i] = '0;
      ff_coef[i] = '0;
      fb_coef[i] = '0;
    end
    mismatches = 0;
  endfunction

  // Round a Q.39 sum half up to Q.23.
  function longint round_q23(longint acc);
    return (acc + 64'sd32768) >>> 16;
  endfunction

  // Update the coefficient tables or run one sample through the filter.
  function void note_item(iirdf2_pkg::act_t action, logic signed [23:0] sample,
                          logic [2:0] slot, logic signed [31:0] value);
    longint acc;
    longint w;
    longint y;
    int ff;
    int fb;
    logic clip;
    case (action)
      iirdf2_pkg::ACT_WR_FF: ff_coef[slot] = value;
      iirdf2_pkg::ACT_WR_FB: fb_coef[slot] = value;
      iirdf2_pkg::ACT_SAMPLE: begin
        ff = (ff_order > 4'd8) ? NTAPS : int'(ff_order);
        fb = (fb_order > 4'd8) ? NTAPS : int'(fb_order);
        clip = 1'b0;
        // Feedback pass forms the auxiliary value; tap zero is never used.
        acc = longint'(sample) <<< 39;
        for (int j = 1; j < fb; j++) begin
          acc += (longint'(fb_coef[j]) * longint'(aux_line[j-1])) >>> 13;
        end
        w = round_q23(acc);
        if (w > HIST_MAX) begin
          w = HIST_MAX;
          clip = 1'b1;
        end else if (w < HIST_MIN) begin
          w = HIST_MIN;
          clip = 1'b1;
        end
        for (int j = NTAPS - 1; j > 0; j--) begin
          aux_line[j] = aux_line[j-1];
        end
        aux_line[0] = w[31:0];
        // Feedforward pass over the updated delay line.
        acc = 0;
        for (int j = 0; j < ff; j++) begin
          acc += (longint'(ff_coef[j]) * longint'(aux_line[j])) >>> 13;
        end
        y = round_q23(acc);
        if (y > OUT_MAX) begin
          y = OUT_MAX;
          clip = 1'b1;
        end else if (y < OUT_MIN) begin
          y = OUT_MIN;
          clip = 1'b1;
        end
        expected_outputs.push_back({clip, y[23:0]});
      end
      default: ;
    endcase
  endfunction

  // Compare one output item with the oldest prediction.
  function void check_output(logic [23:0] sample_out, logic saturated);
    logic [24:0] want;
    if (expected_outputs.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Unexpected output item: sample_out=%h saturated=%b", sample_out, saturated);
      end
      return;
    end
    want = expected_outputs.pop_front();
    if (want[23:0] !== sample_out || want[24] !== saturated) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Output mismatch: expected sample_out=%h saturated=%b, got sample_out=%h saturated=%b",
                 want[23:0], want[24], sample_out, saturated);
      end
    end
  endfunction
endclass

module iir_filter_direct_form_two_tb;
  import iirdf2_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 48;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [63:0] in_tdata;          // sample_in[23:0], coef_index[26:24], coef_value[58:27]
  logic [ACT_W-1:0] in_tuser;     // action[1:0]
  logic out_tvalid;
  logic out_tready;
  logic [SAMPLE_W-1:0] out_tdata; // sample_out[23:0]
  logic out_tuser;                // saturated[0]
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ORD_W-1:0] cfg_data;

  df2_output_board board;
  bit idle_en;
  int stall_left;
  int cycle_count;

  iir_filter_direct_form_two #(.TAPS(8)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Output side: check accepted items and stall in random bursts.
  initial begin
    out_tready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        board.check_output(out_tdata, out_tuser);
      end
      if (stall_left == 0 && idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one item, with an optional idle burst first, and wait for acceptance.
  task automatic send_item(act_t action, logic [23:0] sample, logic [2:0] slot,
                           logic [31:0] value);
    int gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= action;
    in_tdata <= {5'd0, value, slot, sample};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_item(action, sample, slot, value);
  endtask

  // Stop sending and wait until every predicted output has come.
  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    while (board.expected_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both order registers on consecutive cycles.
  task automatic write_orders(logic [3:0] ff, logic [3:0] fb);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_FF_ORDER;
    cfg_data <= ff;
    @(posedge clk);
    cfg_index <= CFG_FB_ORDER;
    cfg_data <= fb;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.ff_order = ff;
    board.fb_order = fb;
  endtask

  // Samples of every magnitude, with the extremes mixed in.
  function automatic logic [23:0] random_sample();
    logic [31:0] r;
    logic signed [23:0] s;
    r = $urandom;
    s = r[23:0];
    case ($urandom_range(0, 9))
      0: s = 24'h7FFFFF;
      1: s = 24'h800000;
      default: s = s >>> $urandom_range(0, 23);
    endcase
    return s;
  endfunction

  // Coefficients no larger in magnitude than 4.0 / 2^min_shift.
  function automatic logic [31:0] random_coef(int min_shift);
    logic signed [31:0] c;
    c = $urandom;
    return c >>> $urandom_range(min_shift, 31);
  endfunction

  initial begin
    int count;
    int pick;
    logic [3:0] ff;
    logic [3:0] fb;
    board = new();
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= ACT_SAMPLE;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_FF_ORDER;
    cfg_data <= '0;
    idle_en = 1'b0;
    cycle_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset orders, empty tables, unused feedback tap, ignored action.
    send_item(ACT_SAMPLE, 24'h7FFFFF, 3'd0, 32'd0);
    send_item(ACT_WR_FF, 24'd0, 3'd0, 32'h2000_0000);
    send_item(ACT_SAMPLE, 24'h7FFFFF, 3'd0, 32'd0);
    send_item(ACT_SAMPLE, 24'h800000, 3'd0, 32'd0);
    send_item(ACT_WR_FB, 24'd0, 3'd0, 32'h8000_0000);
    send_item(ACT_NONE, 24'hFFFFFF, 3'd7, 32'hFFFF_FFFF);
    send_item(ACT_WR_FF, 24'd0, 3'd7, 32'h7FFF_FFFF);
    send_item(ACT_SAMPLE, 24'h000001, 3'd0, 32'd0);
    drain_outputs();

    // Directed: full orders with a strong feedback tap to clip w and the output.
    write_orders(4'd8, 4'd8);
    send_item(ACT_WR_FB, 24'd0, 3'd1, 32'h7FFF_FFFF);
    repeat (4) send_item(ACT_SAMPLE, 24'h7FFFFF, 3'd0, 32'd0);
    send_item(ACT_WR_FF, 24'd0, 3'd0, 32'h8000_0000);
    send_item(ACT_SAMPLE, 24'd0, 3'd0, 32'd0);
    drain_outputs();

    // Directed: orders above the tap count are clamped.
    write_orders(4'd15, 4'd15);
    send_item(ACT_SAMPLE, 24'h800000, 3'd0, 32'd0);
    send_item(ACT_WR_FB, 24'd0, 3'd7, 32'h8000_0000);
    send_item(ACT_SAMPLE, 24'hFFFFFF, 3'd0, 32'd0);
    drain_outputs();

    // Directed: order zero gives a zero output and no feedback.
    write_orders(4'd0, 4'd0);
    send_item(ACT_SAMPLE, 24'h7FFFFF, 3'd0, 32'd0);
    send_item(ACT_SAMPLE, 24'h000001, 3'd0, 32'd0);
    drain_outputs();

    // Random phases, each with its own orders, table load and item mix.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin ff = 4'd1; fb = 4'd8; end
        1: begin ff = 4'd8; fb = 4'd1; end
        2: begin ff = 4'd15; fb = 4'd2; end
        3: begin ff = 4'd0; fb = 4'd8; end
        default: begin
          ff = 4'($urandom_range(0, 15));
          fb = 4'($urandom_range(0, 15));
        end
      endcase
      idle_en = (p < PHASES - 2) ? ($urandom_range(0, 3) != 0) : 1'b0;
      write_orders(ff, fb);
      count = 0;
      // Load both tables with moderate coefficients so the filter stays mostly in range.
      for (int i = 0; i < 8; i++) begin
        send_item(ACT_WR_FF, random_sample(), 3'(i), random_coef(2));
        send_item(ACT_WR_FB, random_sample(), 3'(i), random_coef(4));
        count += 2;
      end
      while (count < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          send_item(ACT_NONE, random_sample(), 3'($urandom_range(0, 7)), $urandom);
        end else if (pick < 70) begin
          send_item(ACT_SAMPLE, random_sample(), 3'($urandom_range(0, 7)), $urandom);
          count++;
        end else if (pick < 85) begin
          send_item(ACT_WR_FF, random_sample(), 3'($urandom_range(0, 7)), random_coef(0));
          count++;
        end else begin
          send_item(ACT_WR_FB, random_sample(), 3'($urandom_range(0, 7)), random_coef(1));
          count++;
        end
      end
      drain_outputs();
    end

    if (board.mismatches == 0 && board.expected_outputs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/iirdf2_pkg.sv
design/iirdf2_coef_mem.sv
design/iirdf2_hist_mem.sv
design/iirdf2_mac.sv
design/iir_filter_direct_form_two.sv
dv/iir_filter_direct_form_two_tb.sv
